@@ hdl/wavhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavhp_pkg: shared types and constants of the WAV header parser
// Result codes, parse phases, header tags, header byte positions and the
// word types passed between the input register, parser and result register.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PHASE_IDLE    = 2'd0,
		PHASE_HEADER  = 2'd1,
		PHASE_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_TAG      = 3'd1,
		ERR_FMT_SIZE = 3'd2,
		ERR_NOT_PCM  = 3'd3,
		ERR_NO_DATA  = 3'd4,
		ERR_TRUNC    = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		FMT_MONO8    = 3'd0,
		FMT_MONO16   = 3'd1,
		FMT_STEREO8  = 3'd2,
		FMT_STEREO16 = 3'd3,
		FMT_UNSUP    = 3'd4
	} fmt_t;

	// Little-endian tags as they sit in the shift register after four bytes
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
	localparam logic [15:0] AUDIO_PCM      = 16'd1;

	// Header byte index of the last byte of each checked or kept field
	localparam logic [5:0] POS_RIFF      = 6'd3;
	localparam logic [5:0] POS_WAVE      = 6'd11;
	localparam logic [5:0] POS_FMT       = 6'd15;
	localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
	localparam logic [5:0] POS_AUDIO_FMT = 6'd21;
	localparam logic [5:0] POS_CHANNELS  = 6'd23;
	localparam logic [5:0] POS_RATE      = 6'd27;
	localparam logic [5:0] POS_BITS      = 6'd35;
	localparam logic [5:0] POS_DATA      = 6'd39;
	localparam logic [5:0] POS_DATA_SIZE = 6'd43;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       file_start;
		logic       file_end;
	} in_word_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		fmt_t        format_code;
		logic [31:0] payload_size;
		err_t        error_code;
		logic        run_last;
	} res_word_t;

	function automatic fmt_t format_of(input logic [15:0] ch, input logic [15:0] bits);
		fmt_t f;
		f = FMT_UNSUP;
		if (ch == 16'd1 && bits == 16'd8)  f = FMT_MONO8;
		if (ch == 16'd1 && bits == 16'd16) f = FMT_MONO16;
		if (ch == 16'd2 && bits == 16'd8)  f = FMT_STEREO8;
		if (ch == 16'd2 && bits == 16'd16) f = FMT_STEREO16;
		return f;
	endfunction

endpackage

@@ hdl/wavhp_in_reg.sv @@
// ----------------------------------------------------------------------------
// wavhp_in_reg: input word register
// Holds one accepted file word until the parser takes it; refills in the
// same cycle the held word is taken.
// ----------------------------------------------------------------------------
module wavhp_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wavhp_pkg::in_word_t in_word,
	input  logic                take,
	output logic                valid_s1,
	output wavhp_pkg::in_word_t word_s1
);

	// accept when empty or when the held word leaves this cycle
	assign in_ready = !valid_s1 || take;

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// load the word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

endmodule

@@ hdl/wavhp_parse.sv @@
// ----------------------------------------------------------------------------
// wavhp_parse: header parse state and per-word decision
// Tracks the header byte index and the little-endian shift register, checks
// tags and fields, keeps fmt fields and counts down the payload.
// ----------------------------------------------------------------------------
module wavhp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  wavhp_pkg::in_word_t  item,
	input  logic                 out_free,
	output logic                 take,
	output logic                 res_valid,
	output wavhp_pkg::res_word_t res
);

	wavhp_pkg::phase_t phase_q, phase_d, phase_eff;
	logic [5:0]  pos_q, pos_d, pos_eff;
	logic [31:0] shift_q, shift_d, shift_new;
	logic [15:0] ch_q, ch_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] remain_q, remain_d, rem_new;
	logic        has_res;
	logic        hdr_done;
	wavhp_pkg::err_t err;

	// decide the result and next state for the held word
	always_comb begin
		phase_eff = item.file_start ? wavhp_pkg::PHASE_HEADER : phase_q;
		pos_eff   = item.file_start ? 6'd0 : pos_q;
		shift_new = {item.file_byte, shift_q[31:8]};
		rem_new   = remain_q - 32'd1;
		phase_d   = phase_eff;
		pos_d     = pos_eff;
		shift_d   = shift_q;
		ch_d      = ch_q;
		rate_d    = rate_q;
		bits_d    = bits_q;
		remain_d  = remain_q;
		has_res   = 1'b0;
		hdr_done  = 1'b0;
		err       = wavhp_pkg::ERR_NONE;
		res       = '0;
		case (phase_eff)
			wavhp_pkg::PHASE_PAYLOAD: begin
				remain_d = rem_new;
				has_res  = 1'b1;
				if (rem_new != 32'd0 && item.file_end) begin
					res.result_kind = wavhp_pkg::KIND_ERROR;
					res.error_code  = wavhp_pkg::ERR_TRUNC;
					res.run_last    = 1'b1;
					phase_d         = wavhp_pkg::PHASE_IDLE;
				end else begin
					res.result_kind  = wavhp_pkg::KIND_PAYLOAD;
					res.payload_byte = item.file_byte;
					if (rem_new == 32'd0) begin
						res.run_last = 1'b1;
						phase_d      = wavhp_pkg::PHASE_IDLE;
					end
				end
			end
			wavhp_pkg::PHASE_HEADER: begin
				shift_d = shift_new;
				pos_d   = pos_eff + 6'd1;
				// check or keep the field that ends on this byte
				case (pos_eff)
					wavhp_pkg::POS_RIFF:
						if (shift_new != wavhp_pkg::TAG_RIFF) err = wavhp_pkg::ERR_TAG;
					wavhp_pkg::POS_WAVE:
						if (shift_new != wavhp_pkg::TAG_WAVE) err = wavhp_pkg::ERR_TAG;
					wavhp_pkg::POS_FMT:
						if (shift_new != wavhp_pkg::TAG_FMT) err = wavhp_pkg::ERR_TAG;
					wavhp_pkg::POS_FMT_SIZE:
						if (shift_new != wavhp_pkg::FMT_CHUNK_SIZE) err = wavhp_pkg::ERR_FMT_SIZE;
					wavhp_pkg::POS_AUDIO_FMT:
						if (shift_new[31:16] != wavhp_pkg::AUDIO_PCM) err = wavhp_pkg::ERR_NOT_PCM;
					wavhp_pkg::POS_CHANNELS: ch_d   = shift_new[31:16];
					wavhp_pkg::POS_RATE:     rate_d = shift_new;
					wavhp_pkg::POS_BITS:     bits_d = shift_new[31:16];
					wavhp_pkg::POS_DATA:
						if (shift_new != wavhp_pkg::TAG_DATA) err = wavhp_pkg::ERR_NO_DATA;
					wavhp_pkg::POS_DATA_SIZE: hdr_done = 1'b1;
					default: ;
				endcase
				if (hdr_done) begin
					remain_d = shift_new;
				end
				// a failed check wins over an early end
				if (err != wavhp_pkg::ERR_NONE) begin
					has_res = 1'b1;
				end else if (item.file_end && !(hdr_done && shift_new == 32'd0)) begin
					err     = wavhp_pkg::ERR_TRUNC;
					has_res = 1'b1;
				end else if (hdr_done) begin
					has_res           = 1'b1;
					res.result_kind   = wavhp_pkg::KIND_HEADER;
					res.channel_count = ch_q;
					res.sample_rate   = rate_q;
					res.sample_bits   = bits_q;
					res.format_code   = wavhp_pkg::format_of(ch_q, bits_q);
					res.payload_size  = shift_new;
					if (shift_new == 32'd0) begin
						res.run_last = 1'b1;
						phase_d      = wavhp_pkg::PHASE_IDLE;
					end else begin
						phase_d = wavhp_pkg::PHASE_PAYLOAD;
					end
				end
				if (err != wavhp_pkg::ERR_NONE) begin
					res.result_kind = wavhp_pkg::KIND_ERROR;
					res.error_code  = err;
					res.run_last    = 1'b1;
					phase_d         = wavhp_pkg::PHASE_IDLE;
				end
			end
			default: ;
		endcase
	end

	// take the word when its result, if any, has room
	assign take      = item_valid && (out_free || !has_res);
	assign res_valid = take && has_res;

	// hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wavhp_pkg::PHASE_IDLE;
			pos_q    <= 6'd0;
			shift_q  <= 32'd0;
			ch_q     <= 16'd0;
			rate_q   <= 32'd0;
			bits_q   <= 16'd0;
			remain_q <= 32'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			ch_q     <= ch_d;
			rate_q   <= rate_d;
			bits_q   <= bits_d;
			remain_q <= remain_d;
		end
	end

endmodule

@@ hdl/wavhp_out_reg.sv @@
// ----------------------------------------------------------------------------
// wavhp_out_reg: result register
// Holds one result word for the output channel; a new result may load in
// the cycle the held one is taken.
// ----------------------------------------------------------------------------
module wavhp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  wavhp_pkg::res_word_t res,
	output logic                 free,
	output logic                 valid_s2,
	output wavhp_pkg::res_word_t res_s2,
	input  logic                 out_ready
);

	assign free = !valid_s2 || out_ready;

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

@@ hdl/wav_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser_unit: RIFF/WAVE PCM header parser
// Parses the canonical 44-byte WAV header from a byte stream and passes the
// payload bytes through.
// ----------------------------------------------------------------------------
// Takes one file word per cycle unless the output stalls; an accepted word
// reaches the output via the input register, then the result register. Each
// word is decided combinationally by a byte-index compare and a 32-bit shift.
// A word with file_start restarts the parse; after the final result of a file
// (run_last) words are dropped until the next file_start. Only the last and a
// failing header word give a result; bytes after the data chunk give none.
// Stalls on the output hold the input only once the input register is full.
module wav_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        file_start,
	input  logic        file_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [2:0]  format_code,
	output logic [31:0] payload_size,
	output logic [2:0]  error_code,
	output logic        run_last
);

	wavhp_pkg::in_word_t  in_word, word_s1;
	wavhp_pkg::res_word_t res, res_s2;
	logic valid_s1, take, res_valid, free;

	assign in_word.file_byte  = file_byte;
	assign in_word.file_start = file_start;
	assign in_word.file_end   = file_end;

	wavhp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	wavhp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (word_s1),
		.out_free   (free),
		.take       (take),
		.res_valid  (res_valid),
		.res        (res)
	);

	wavhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (free),
		.valid_s2  (out_valid),
		.res_s2    (res_s2),
		.out_ready (out_ready)
	);

	// unpack the result word onto the ports
	assign result_kind   = res_s2.result_kind;
	assign payload_byte  = res_s2.payload_byte;
	assign channel_count = res_s2.channel_count;
	assign sample_rate   = res_s2.sample_rate;
	assign sample_bits   = res_s2.sample_bits;
	assign format_code   = res_s2.format_code;
	assign payload_size  = res_s2.payload_size;
	assign error_code    = res_s2.error_code;
	assign run_last      = res_s2.run_last;

endmodule
